[rtl/smpq_pkg.sv]
// Shared types, constants and helpers for the stable minimum priority queue.
// No dependencies; the datapath, controller and top level import this package.
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int CAPACITY    = 16;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int DATA_W      = 32;
  localparam int ENTRY_W     = 2 * DATA_W;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int IN_DATA_W   = 2 * DATA_W;
  localparam int OUT_DATA_W  = 104;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_DEQ_RD,
    S_DEQ_CAP,
    S_HEAD_RD,
    S_HEAD_CAP,
    S_DONE
  } state_t;

  typedef enum logic {
    RD_PREV,
    RD_HEAD
  } rd_sel_t;

  typedef struct packed {
    logic    ld_item;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    idx_dec;
    logic    cnt_inc;
    logic    deq_commit;
    logic    cap_removed;
    logic    cap_head;
    logic    ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_deq;
    logic fault;
    logic idx_zero;
    logic shift;
  } dp_stat_t;

  // logical slot to physical RAM address, ring of CAPACITY entries
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] slot);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, slot};
    if (sum >= (IDX_W + 1)'(CAPACITY)) begin
      sum = sum - (IDX_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  // reported count wraps at 32
  function automatic logic [COUNT_OUT_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_OUT_W-1:0] ext;
    ext = {{COUNT_OUT_W{1'b0}}, c};
    return ext[COUNT_OUT_W-1:0];
  endfunction

endpackage

[rtl/smpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module smpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/smpq_datapath.sv]
// Datapath: entry RAM kept as a ring, occupancy and ring base, item and result registers.
// Depends on smpq_pkg and smpq_ram.
`timescale 1ns / 1ps

module smpq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  smpq_pkg::dp_cmd_t                   cmd,
  output smpq_pkg::dp_stat_t                  stat,
  input  logic                                s_tuser,
  input  logic [smpq_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic [smpq_pkg::STATUS_W-1:0]       m_tuser,
  output logic [smpq_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import smpq_pkg::*;

  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       base;
  logic [IDX_W-1:0]       idx;
  logic                   item_cmd;
  logic [DATA_W-1:0]      item_value;
  logic [DATA_W-1:0]      item_weight;
  logic [STATUS_W-1:0]    status;
  logic [DATA_W-1:0]      removed_value;
  logic [DATA_W-1:0]      removed_weight;
  logic [DATA_W-1:0]      head_value;

  logic [STATUS_W-1:0]    o_status;
  logic [DATA_W-1:0]      o_removed_value;
  logic [DATA_W-1:0]      o_removed_weight;
  logic                   o_head_valid;
  logic [DATA_W-1:0]      o_head_value;
  logic [COUNT_OUT_W-1:0] o_count;

  logic [IDX_W-1:0]       waddr;
  logic [IDX_W-1:0]       raddr;
  logic [ENTRY_W-1:0]     wdata;
  logic [ENTRY_W-1:0]     rdata;
  logic [STATUS_W-1:0]    status_next;
  logic                   held;

  // entry layout: weight in the upper half
  smpq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign waddr = phys(base, idx);
  assign wdata = cmd.wr_new ? {item_weight, item_value} : rdata;
  assign raddr = (cmd.rd_sel == RD_HEAD) ? base : phys(base, idx - IDX_W'(1));
  assign held  = (count != '0);

  always_comb begin
    status_next = ST_DONE;
    if (s_tuser == CMD_ENQ) begin
      if (count == CNT_W'(CAPACITY)) begin
        status_next = ST_FULL;
      end
    end else begin
      if (count == '0) begin
        status_next = ST_EMPTY;
      end
    end
  end

  assign stat.is_deq   = (item_cmd == CMD_DEQ);
  assign stat.fault    = (status != ST_DONE);
  assign stat.idx_zero = (idx == '0);
  // held entry moves up one slot only if strictly heavier: keeps arrival order
  assign stat.shift    = $signed(rdata[ENTRY_W-1:DATA_W]) > $signed(item_weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      base  <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.deq_commit) begin
        count <= count - CNT_W'(1);
        if (base == IDX_W'(CAPACITY - 1)) begin
          base <= '0;
        end else begin
          base <= base + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      item_cmd       <= s_tuser;
      item_value     <= s_tdata[DATA_W-1:0];
      item_weight    <= s_tdata[IN_DATA_W-1:DATA_W];
      status         <= status_next;
      idx            <= count[IDX_W-1:0];
      removed_value  <= '0;
      removed_weight <= '0;
    end else begin
      if (cmd.idx_dec) begin
        idx <= idx - IDX_W'(1);
      end
      if (cmd.cap_removed) begin
        removed_value  <= rdata[DATA_W-1:0];
        removed_weight <= rdata[ENTRY_W-1:DATA_W];
      end
    end
    if (cmd.cap_head) begin
      head_value <= rdata[DATA_W-1:0];
    end
    if (cmd.ld_out) begin
      o_status         <= status;
      o_removed_value  <= removed_value;
      o_removed_weight <= removed_weight;
      o_head_valid     <= held;
      o_head_value     <= held ? head_value : '0;
      o_count          <= count_field(count);
    end
  end

  assign m_tuser = o_status;
  assign m_tdata = {2'b00, o_count, o_head_value, o_head_valid,
                    o_removed_weight, o_removed_value};

endmodule

[rtl/smpq_ctrl.sv]
// Controller: sequences one item at a time through the datapath and owns the result valid.
// Depends on smpq_pkg.
`timescale 1ns / 1ps

module smpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  smpq_pkg::dp_stat_t stat,
  output smpq_pkg::dp_cmd_t  cmd
);
  import smpq_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.ld_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.fault) begin
          state_next = S_HEAD_RD;
        end else if (stat.is_deq) begin
          state_next = S_DEQ_RD;
        end else begin
          state_next = S_ENQ_RD;
        end
      end
      S_ENQ_RD: begin
        state_next = stat.idx_zero ? S_HEAD_RD : S_ENQ_CMP;
      end
      S_ENQ_CMP: begin
        state_next = stat.shift ? S_ENQ_RD : S_HEAD_RD;
      end
      S_DEQ_RD:   state_next = S_DEQ_CAP;
      S_DEQ_CAP:  state_next = S_HEAD_RD;
      S_HEAD_RD:  state_next = S_HEAD_CAP;
      S_HEAD_CAP: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_PREV;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        // no item is taken while reset is held
        s_tready    = !rst;
        cmd.ld_item = s_tvalid && !rst;
      end
      S_ENQ_RD: begin
        if (stat.idx_zero) begin
          // reached the front: new entry goes to slot 0
          cmd.wr_en   = 1'b1;
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_ENQ_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.shift) begin
          cmd.idx_dec = 1'b1;
        end else begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_DEQ_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HEAD;
      end
      S_DEQ_CAP: begin
        cmd.cap_removed = 1'b1;
        cmd.deq_commit  = 1'b1;
      end
      S_HEAD_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HEAD;
      end
      S_HEAD_CAP: begin
        cmd.cap_head = 1'b1;
      end
      S_DONE: begin
        cmd.ld_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/stable_min_priority_queue.sv]
// Stable minimum priority queue, up to CAPACITY (value, weight) entries held in a ring
// RAM in ascending weight order; equal weights leave in arrival order. One item is
// worked at a time. On an enqueue, each held entry heavier than the new one is moved
// one slot back by a read and a write through the single RAM port pair. A refused item
// (enqueue when full, dequeue when empty) leaves the entries as they were. The next item
// is taken while a result still waits on the output side; a second finished result
// holds the block until the first one has left.
// Depends on smpq_pkg, smpq_ctrl, smpq_datapath, smpq_ram.
`timescale 1ns / 1ps

module stable_min_priority_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic                                s_tuser,  // command
  input  logic [smpq_pkg::IN_DATA_W-1:0]      s_tdata,  // item_value, item_weight
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [smpq_pkg::STATUS_W-1:0]       m_tuser,  // status
  // removed_value, removed_weight, head_valid, head_value, entry_count, 2 pad bits
  output logic [smpq_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import smpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  smpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  smpq_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .m_tuser (m_tuser),
    .m_tdata (m_tdata)
  );

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending one");

  // refused items never touch the entry store
  a_fault_no_write: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !stat.fault)
    else $error("write during refused item");

  // intake, store update and result load are separate phases
  a_phases: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.ld_item, cmd.wr_en, cmd.deq_commit, cmd.ld_out}))
    else $error("overlapping datapath phases");

  // after a result is loaded the block is ready for the next item
  a_ready_after_out: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |=> s_tready)
    else $error("not ready after result");

endmodule
